// ===== hdl/hcd_pkg.sv =====
// Package: shared constants, types and mod-26 helpers for the Hill decrypt unit
package hcd_pkg;

    localparam int unsigned DIM       = 3;
    localparam int unsigned MODULUS   = 26;
    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned KEY_ROW_W = DIM * LETTER_W;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PROD_W    = 2 * LETTER_W;       // 5x5 product
    localparam int unsigned SUM_W     = PROD_W + 2;         // sum of three products
    localparam int unsigned RED_W     = 12;                 // mod26 input width
    localparam int unsigned RECIP_SH  = 16;
    localparam int unsigned RECIP_26  = 2521;               // ceil(2^16 / 26)
    localparam int unsigned ADJ_W     = 11;
    localparam int unsigned ADJ_BIAS  = MODULUS * MODULUS;  // keeps cofactors positive

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROW_ZERO = 2'd0,
        CFG_KEY_ROW_ONE  = 2'd1,
        CFG_KEY_ROW_TWO  = 2'd2
    } t_cfg_idx;

    typedef logic [LETTER_W-1:0] t_letter;

    // inverse key as seen by the datapath, plus derivation status
    typedef struct packed {
        logic [DIM-1:0][DIM-1:0][LETTER_W-1:0] entries;
        logic                                  ready;
        logic                                  busy;
    } t_inv_key;

    // v mod 26 for v < 4096: reciprocal multiply, remainder is exact in range
    function automatic t_letter mod26(input logic [RED_W-1:0] v);
        logic [2*RED_W-1:0] p;
        logic [RED_W-1:0]   q;
        logic [RED_W-1:0]   r;
        p = (2*RED_W)'(v) * (2*RED_W)'(RECIP_26);
        q = RED_W'(p >> RECIP_SH);
        r = v - RED_W'(q * RED_W'(MODULUS));
        return LETTER_W'(r);
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic t_letter inv26(input t_letter d);
        t_letter x;
        case (d)
            5'd1:    x = 5'd1;
            5'd3:    x = 5'd9;
            5'd5:    x = 5'd21;
            5'd7:    x = 5'd15;
            5'd9:    x = 5'd3;
            5'd11:   x = 5'd19;
            5'd15:   x = 5'd7;
            5'd17:   x = 5'd23;
            5'd19:   x = 5'd11;
            5'd21:   x = 5'd5;
            5'd23:   x = 5'd17;
            5'd25:   x = 5'd25;
            default: x = 5'd0;
        endcase
        return x;
    endfunction

endpackage

// ===== hdl/hcd_if.sv =====
// Interfaces: ciphertext, plaintext and configuration channels
interface hcd_cipher_if;
    logic               valid;
    logic               ready;
    hcd_pkg::t_letter   cipher_letter_a;
    hcd_pkg::t_letter   cipher_letter_b;
    hcd_pkg::t_letter   cipher_letter_c;
    modport source(output valid, cipher_letter_a, cipher_letter_b, cipher_letter_c,
                   input ready);
    modport sink(input valid, cipher_letter_a, cipher_letter_b, cipher_letter_c,
                 output ready);
endinterface

interface hcd_plain_if;
    logic               valid;
    logic               ready;
    hcd_pkg::t_letter   plain_letter_a;
    hcd_pkg::t_letter   plain_letter_b;
    hcd_pkg::t_letter   plain_letter_c;
    logic               key_not_invertible;
    modport source(output valid, plain_letter_a, plain_letter_b, plain_letter_c,
                   key_not_invertible, input ready);
    modport sink(input valid, plain_letter_a, plain_letter_b, plain_letter_c,
                 key_not_invertible, output ready);
endinterface

interface hcd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [hcd_pkg::CFG_IDX_W-1:0]        index;
    logic [hcd_pkg::KEY_ROW_W-1:0]        data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/hcd_key_deriv.sv =====
// Key store and multi-cycle derivation of the inverse key mod 26
module hcd_key_deriv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcd_cfg_if.sink           i_cfg,
    output hcd_pkg::t_inv_key o_key
);
    localparam int unsigned N = hcd_pkg::DIM;
    localparam int unsigned W = hcd_pkg::LETTER_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REDUCE = 8'b0000_0010,
        ST_ADJ    = 8'b0000_0100,
        ST_ADJMOD = 8'b0000_1000,
        ST_DET    = 8'b0001_0000,
        ST_DINV   = 8'b0010_0000,
        ST_INVP   = 8'b0100_0000,
        ST_INV    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [N-1:0][hcd_pkg::KEY_ROW_W-1:0]     r_key_row;
    logic [N-1:0][N-1:0][W-1:0]               r_k;
    logic [N-1:0][N-1:0][hcd_pkg::ADJ_W-1:0]  r_adj;
    logic [N-1:0][N-1:0][W-1:0]               r_adjm;
    logic [hcd_pkg::SUM_W-1:0]                r_det;
    logic [W-1:0]                             r_dinv;
    logic [N-1:0][N-1:0][hcd_pkg::PROD_W-1:0] r_prod;
    logic [N-1:0][N-1:0][W-1:0]               r_inv;
    logic                                     r_ready;

    logic cfg_wr;

    // a*b - c*d biased by 26*26 so it stays positive and keeps its residue
    function automatic logic [hcd_pkg::ADJ_W-1:0] cofactor(
        input logic [W-1:0] a, input logic [W-1:0] b,
        input logic [W-1:0] c, input logic [W-1:0] d);
        logic [hcd_pkg::ADJ_W-1:0] pos;
        logic [hcd_pkg::ADJ_W-1:0] neg;
        pos = hcd_pkg::ADJ_W'(a) * hcd_pkg::ADJ_W'(b);
        neg = hcd_pkg::ADJ_W'(c) * hcd_pkg::ADJ_W'(d);
        return pos + hcd_pkg::ADJ_W'(hcd_pkg::ADJ_BIAS) - neg;
    endfunction

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = cfg_wr ? ST_REDUCE : ST_IDLE;
            ST_REDUCE: n_state = ST_ADJ;
            ST_ADJ:    n_state = ST_ADJMOD;
            ST_ADJMOD: n_state = ST_DET;
            ST_DET:    n_state = ST_DINV;
            ST_DINV:   n_state = ST_INVP;
            ST_INVP:   n_state = ST_INV;
            ST_INV:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_key_row <= '0;
            r_ready   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_cfg.index)
                    hcd_pkg::CFG_KEY_ROW_ZERO: r_key_row[0] <= i_cfg.data;
                    hcd_pkg::CFG_KEY_ROW_ONE:  r_key_row[1] <= i_cfg.data;
                    hcd_pkg::CFG_KEY_ROW_TWO:  r_key_row[2] <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == ST_INV) begin
                r_ready <= (r_dinv != '0);
            end
        end
    end

    // derivation chain runs freely; the sequencer only times the final load
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                if (r_key_row[r][W*c +: W] >= W'(hcd_pkg::MODULUS)) begin
                    r_k[r][c] <= r_key_row[r][W*c +: W] - W'(hcd_pkg::MODULUS);
                end else begin
                    r_k[r][c] <= r_key_row[r][W*c +: W];
                end
                r_adjm[r][c] <= hcd_pkg::mod26(hcd_pkg::RED_W'(r_adj[r][c]));
                r_prod[r][c] <= hcd_pkg::PROD_W'(r_dinv) * hcd_pkg::PROD_W'(r_adjm[r][c]);
            end
        end

        r_adj[0][0] <= cofactor(r_k[1][1], r_k[2][2], r_k[1][2], r_k[2][1]);
        r_adj[0][1] <= cofactor(r_k[0][2], r_k[2][1], r_k[0][1], r_k[2][2]);
        r_adj[0][2] <= cofactor(r_k[0][1], r_k[1][2], r_k[0][2], r_k[1][1]);
        r_adj[1][0] <= cofactor(r_k[1][2], r_k[2][0], r_k[1][0], r_k[2][2]);
        r_adj[1][1] <= cofactor(r_k[0][0], r_k[2][2], r_k[0][2], r_k[2][0]);
        r_adj[1][2] <= cofactor(r_k[0][2], r_k[1][0], r_k[0][0], r_k[1][2]);
        r_adj[2][0] <= cofactor(r_k[1][0], r_k[2][1], r_k[1][1], r_k[2][0]);
        r_adj[2][1] <= cofactor(r_k[0][1], r_k[2][0], r_k[0][0], r_k[2][1]);
        r_adj[2][2] <= cofactor(r_k[0][0], r_k[1][1], r_k[0][1], r_k[1][0]);

        // determinant by first-row expansion against the reduced cofactors
        r_det  <= hcd_pkg::SUM_W'(hcd_pkg::PROD_W'(r_k[0][0]) * hcd_pkg::PROD_W'(r_adjm[0][0]))
                + hcd_pkg::SUM_W'(hcd_pkg::PROD_W'(r_k[0][1]) * hcd_pkg::PROD_W'(r_adjm[1][0]))
                + hcd_pkg::SUM_W'(hcd_pkg::PROD_W'(r_k[0][2]) * hcd_pkg::PROD_W'(r_adjm[2][0]));
        r_dinv <= hcd_pkg::inv26(hcd_pkg::mod26(hcd_pkg::RED_W'(r_det)));

        if (r_state == ST_INV) begin
            for (int r = 0; r < N; r++) begin
                for (int c = 0; c < N; c++) begin
                    r_inv[r][c] <= hcd_pkg::mod26(hcd_pkg::RED_W'(r_prod[r][c]));
                end
            end
        end
    end

    assign o_key.entries = r_inv;
    assign o_key.ready   = r_ready;
    assign o_key.busy    = (r_state != ST_IDLE);

endmodule

// ===== hdl/hcd_mat_pipe.sv =====
// Three-stage matrix-vector pipeline mod 26 with per-stage valid and stall
module hcd_mat_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcd_pkg::t_inv_key i_key,
    hcd_cipher_if.sink        i_cipher,
    hcd_plain_if.source       o_plain
);
    localparam int unsigned N = hcd_pkg::DIM;
    localparam int unsigned W = hcd_pkg::LETTER_W;

    logic [N-1:0][W-1:0] in_vec;

    logic                                     r_v1, r_v2, r_v3;
    logic                                     r_nk1, r_nk2, r_nk3;
    logic [N-1:0][N-1:0][hcd_pkg::PROD_W-1:0] r_prod1;
    logic [N-1:0][hcd_pkg::SUM_W-1:0]         r_sum2;
    logic [N-1:0][W-1:0]                      r_out3;

    logic en1, en2, en3, in_acc;

    assign in_vec[0] = i_cipher.cipher_letter_a;
    assign in_vec[1] = i_cipher.cipher_letter_b;
    assign in_vec[2] = i_cipher.cipher_letter_c;

    // a stage moves when it is empty or the stage after it moves
    assign en3            = !r_v3 || o_plain.ready;
    assign en2            = !r_v2 || en3;
    assign en1            = !r_v1 || en2;
    assign i_cipher.ready = en1 && !i_key.busy;
    assign in_acc         = i_cipher.valid && i_cipher.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= in_acc;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_nk1 <= !i_key.ready;
            for (int r = 0; r < N; r++) begin
                for (int c = 0; c < N; c++) begin
                    r_prod1[r][c] <= hcd_pkg::PROD_W'(i_key.entries[r][c])
                                   * hcd_pkg::PROD_W'(in_vec[c]);
                end
            end
        end
        if (en2) begin
            r_nk2 <= r_nk1;
            for (int r = 0; r < N; r++) begin
                r_sum2[r] <= hcd_pkg::SUM_W'(r_prod1[r][0]) + hcd_pkg::SUM_W'(r_prod1[r][1])
                           + hcd_pkg::SUM_W'(r_prod1[r][2]);
            end
        end
        if (en3) begin
            r_nk3 <= r_nk2;
            for (int r = 0; r < N; r++) begin
                r_out3[r] <= r_nk2 ? '0 : hcd_pkg::mod26(hcd_pkg::RED_W'(r_sum2[r]));
            end
        end
    end

    assign o_plain.valid              = r_v3;
    assign o_plain.plain_letter_a     = r_out3[0];
    assign o_plain.plain_letter_b     = r_out3[1];
    assign o_plain.plain_letter_c     = r_out3[2];
    assign o_plain.key_not_invertible = r_nk3;

endmodule

// ===== hdl/hill_cipher_3x3_decrypt_unit.sv =====
// Top level: Hill cipher 3x3 decryption mod 26
//
// Usage notes:
//  - i_cfg writes key rows: index 0, 1, 2 are key rows zero..two, each packing
//    three 5-bit entries (column zero in the low bits); index 3 is ignored.
//    Write only while no word is in flight.
//  - After a write the inverse key is rebuilt by an 8-state sequencer:
//    i_cfg and i_cipher drop ready from the accepted write until the sequencer is idle.
//  - i_cipher takes one word of three ciphertext letters; o_plain gives one
//    word of three plaintext letters and the key_not_invertible flag.
//  - A word passes the product, row sum and mod-26 reduction registers in
//    turn before valid rises on o_plain. Throughput: one word per cycle
//    while o_plain is ready and no key rebuild is in progress.
//  - Stall: each stage advances when empty or when the next one advances, so
//    bubbles are squeezed out and a held output stalls the pipe without loss.
//  - Reset (i_rst_n low, synchronous) empties the pipe and clears the key;
//    an all-zero key has no inverse, so words then come out flagged, zeroed.
module hill_cipher_3x3_decrypt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcd_cfg_if.sink     i_cfg,
    hcd_cipher_if.sink  i_cipher,
    hcd_plain_if.source o_plain
);

    hcd_pkg::t_inv_key key;

    // key store and inverse-key derivation
    hcd_key_deriv u_key_deriv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (i_cfg),
        .o_key  (key)
    );

    // per-word decryption datapath
    hcd_mat_pipe u_mat_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key),
        .i_cipher(i_cipher),
        .o_plain (o_plain)
    );

endmodule

// ===== hdl/hcd_checker.sv =====
// Checker: port-level assertions for the Hill decrypt unit, plus its bind
module hcd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_valid,
    input logic             i_cfg_ready,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input hcd_pkg::t_letter i_out_a,
    input hcd_pkg::t_letter i_out_b,
    input hcd_pkg::t_letter i_out_c,
    input logic             i_out_nk
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_a) && $stable(i_out_b) && $stable(i_out_c) && $stable(i_out_nk))
        else $error("output word changed while stalled");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_nk |-> i_out_a == '0 && i_out_b == '0 && i_out_c == '0)
        else $error("flagged word carries nonzero letters");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_a < 5'd26 && i_out_b < 5'd26 && i_out_c < 5'd26)
        else $error("letter code out of range");

    a_rekey_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready && !i_cfg_ready)
        else $error("input taken while inverse key is being rebuilt");

endmodule

bind hill_cipher_3x3_decrypt_unit hcd_checker u_hcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_valid(i_cfg.valid),
    .i_cfg_ready(i_cfg.ready),
    .i_in_ready (i_cipher.ready),
    .i_out_valid(o_plain.valid),
    .i_out_ready(o_plain.ready),
    .i_out_a    (o_plain.plain_letter_a),
    .i_out_b    (o_plain.plain_letter_b),
    .i_out_c    (o_plain.plain_letter_c),
    .i_out_nk   (o_plain.key_not_invertible)
);
